// ----- rtl/core/ackn_pkg.sv -----
// Shared types and constants for the acknowledgement submessage parser.
// Holds the transaction payload structs, the parser-to-emitter structs and the byte offsets.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ackn_pkg;

    // Byte offsets within the submessage header.
    localparam int unsigned POS_W             = 5;
    localparam logic [POS_W-1:0] POS_KIND          = 5'd0;
    localparam logic [POS_W-1:0] POS_FLAGS         = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LAST      = 5'd3;
    localparam logic [POS_W-1:0] POS_ENTITY_FIRST  = 5'd4;
    localparam logic [POS_W-1:0] POS_READER_LAST   = 5'd7;
    localparam logic [POS_W-1:0] POS_WRITER_LAST   = 5'd11;
    localparam logic [POS_W-1:0] POS_ORDERED_FIRST = 5'd12;
    localparam logic [POS_W-1:0] POS_BASE_HI_LAST  = 5'd15;
    localparam logic [POS_W-1:0] POS_BASE_LO_LAST  = 5'd19;
    localparam logic [POS_W-1:0] POS_BITS_LAST     = 5'd23;
    localparam logic [POS_W-1:0] POS_BODY          = 5'd24;

    // Index of the last byte of a four-byte field.
    localparam logic [1:0] K_LAST = 2'd3;

    // Flags bit that selects little-endian order.
    localparam int unsigned FLAG_LITTLE_BIT = 0;

    // Bitmap byte counter width: ceil(2^32 / 32) * 4 needs 30 bits.
    localparam int unsigned LEFT_W = 30;

    // Result kinds.
    localparam logic RES_SEQ     = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] seq_high;
        logic [31:0]        seq_low;
        logic [31:0]        reader_entity;
        logic [31:0]        writer_entity;
        logic [31:0]        count_value;
        logic [7:0]         submessage_kind;
        logic [7:0]         header_flags;
        logic [15:0]        body_length;
        logic [31:0]        bit_count;
        logic               last_result;
    } t_out_item;

    // Header fields held by the parser and copied into every result.
    typedef struct packed {
        logic [7:0]  submessage_kind;
        logic [7:0]  header_flags;
        logic [15:0] body_length;
        logic [31:0] reader_entity;
        logic [31:0] writer_entity;
        logic [31:0] bit_count;
    } t_hdr_info;

    // Work left behind by one input byte: one result per set mask bit, lowest first.
    typedef struct packed {
        logic [7:0]  mask;
        logic [63:0] seq_base;
        logic        result_kind;
        logic [31:0] count_value;
    } t_job;

endpackage

`default_nettype wire

// ----- rtl/core/ackn_parser.sv -----
// Byte-level parser state for the acknowledgement submessage parser.
// Turns each accepted byte into a job for the emitter. Depends on ackn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ackn_parser #(
    parameter int unsigned MAX_BITS = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire ackn_pkg::t_in_item i_item,
    output ackn_pkg::t_job          o_job,
    output ackn_pkg::t_hdr_info     o_hdr
);

    logic [ackn_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                        r_little, n_little;
    logic [31:0]                 r_shift, n_shift;
    logic [31:0]                 r_base_hi, n_base_hi;
    logic [31:0]                 r_base_lo, n_base_lo;
    logic [ackn_pkg::LEFT_W-1:0] r_left, n_left;
    logic [ackn_pkg::LEFT_W-1:0] r_idx, n_idx;
    ackn_pkg::t_hdr_info         r_hdr, n_hdr;

    logic [7:0]  w_b;
    logic        w_end;
    logic [1:0]  w_k;
    logic        w_use_order;
    logic [31:0] w_prev;
    logic [31:0] w_val;
    logic [32:0] w_bit_base;
    logic [32:0] w_ceil;
    logic [32:0] w_i;

    assign w_b   = i_item.data_byte;
    assign w_end = i_item.end_of_message;

    // Byte index within the current field. The length field starts at offset two.
    assign w_k = (r_pos < ackn_pkg::POS_ENTITY_FIRST) ? {1'b0, r_pos[0]} : r_pos[1:0];
    // Entity ids are always taken as received; all other fields follow the flags.
    assign w_use_order = (r_pos < ackn_pkg::POS_ENTITY_FIRST) ||
                         (r_pos >= ackn_pkg::POS_ORDERED_FIRST);
    assign w_prev = (w_k == 2'd0) ? 32'd0 : r_shift;
    assign w_val  = (w_use_order && r_little) ? (w_prev | (32'(w_b) << {w_k, 3'b000}))
                                              : {w_prev[23:0], w_b};
    assign w_ceil = (33'(w_val) + 33'd31) >> 5;
    assign w_bit_base = {r_idx, 3'b000};

    always_comb begin
        n_pos     = r_pos;
        n_little  = r_little;
        n_shift   = r_shift;
        n_base_hi = r_base_hi;
        n_base_lo = r_base_lo;
        n_left    = r_left;
        n_idx     = r_idx;
        n_hdr     = r_hdr;
        o_job     = '0;
        o_job.result_kind = ackn_pkg::RES_SEQ;
        w_i       = '0;
        if (i_accept) begin
            if (r_pos < ackn_pkg::POS_BODY) begin
                if (w_end) begin
                    n_pos   = '0;
                    n_left  = '0;
                    n_shift = '0;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_shift = w_val;
                    unique case (r_pos)
                        ackn_pkg::POS_KIND: begin
                            n_hdr.submessage_kind = w_b;
                        end
                        ackn_pkg::POS_FLAGS: begin
                            n_hdr.header_flags = w_b;
                            n_little = w_b[ackn_pkg::FLAG_LITTLE_BIT];
                        end
                        ackn_pkg::POS_LEN_LAST: begin
                            n_hdr.body_length = w_val[15:0];
                        end
                        ackn_pkg::POS_READER_LAST: begin
                            n_hdr.reader_entity = w_val;
                        end
                        ackn_pkg::POS_WRITER_LAST: begin
                            n_hdr.writer_entity = w_val;
                        end
                        ackn_pkg::POS_BASE_HI_LAST: begin
                            n_base_hi = w_val;
                        end
                        ackn_pkg::POS_BASE_LO_LAST: begin
                            n_base_lo = w_val;
                        end
                        ackn_pkg::POS_BITS_LAST: begin
                            n_hdr.bit_count = w_val;
                            n_left = {w_ceil[ackn_pkg::LEFT_W-3:0], 2'b00};
                            n_idx  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (r_left != '0) begin
                if (w_end) begin
                    n_pos   = '0;
                    n_left  = '0;
                    n_shift = '0;
                end else begin
                    // Bit j of the job is bitmap bit 7-j of this byte, MSB first.
                    for (int j = 0; j < 8; j++) begin
                        w_i = w_bit_base + 33'(j);
                        o_job.mask[j] = w_b[7-j] && (w_i < {1'b0, r_hdr.bit_count}) &&
                                        (w_i < 33'(MAX_BITS));
                    end
                    o_job.seq_base = {r_base_hi, r_base_lo} + 64'(w_bit_base);
                    n_left = r_left - 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
            end else begin
                if (w_k != ackn_pkg::K_LAST) begin
                    if (w_end) begin
                        n_pos   = '0;
                        n_left  = '0;
                        n_shift = '0;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_shift = w_val;
                    end
                end else begin
                    o_job.mask        = 8'd1;
                    o_job.seq_base    = {r_base_hi, r_base_lo};
                    o_job.result_kind = ackn_pkg::RES_SUMMARY;
                    o_job.count_value = w_val;
                    n_pos   = '0;
                    n_left  = '0;
                    n_shift = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_little  <= 1'b0;
            r_shift   <= '0;
            r_base_hi <= '0;
            r_base_lo <= '0;
            r_left    <= '0;
            r_idx     <= '0;
            r_hdr     <= '0;
        end else begin
            r_pos     <= n_pos;
            r_little  <= n_little;
            r_shift   <= n_shift;
            r_base_hi <= n_base_hi;
            r_base_lo <= n_base_lo;
            r_left    <= n_left;
            r_idx     <= n_idx;
            r_hdr     <= n_hdr;
        end
    end

    assign o_hdr = r_hdr;

endmodule

`default_nettype wire

// ----- rtl/core/ackn_emitter.sv -----
// Job register and result register for the acknowledgement submessage parser.
// Drains one result per cycle from the pending job unless the output stalls. Depends on ackn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ackn_emitter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire ackn_pkg::t_job      i_job,
    input  wire ackn_pkg::t_hdr_info i_hdr,
    output logic                     o_job_free,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ackn_pkg::t_out_item      o_out_data
);

    logic [7:0]          r_mask, n_mask;
    logic [63:0]         r_seq_base;
    logic                r_kind;
    logic [31:0]         r_count;
    logic                r_out_valid, n_out_valid;
    ackn_pkg::t_out_item r_out, n_out;

    logic [7:0]  w_pick;
    logic [7:0]  w_rest;
    logic [2:0]  w_j;
    logic        w_advance;
    logic [63:0] w_seq;

    // Lowest pending bit goes first; it is the earliest bitmap bit.
    assign w_pick = r_mask & (~r_mask + 8'd1);
    assign w_rest = r_mask & ~w_pick;

    always_comb begin
        w_j = '0;
        for (int j = 7; j >= 0; j--) begin
            if (r_mask[j]) begin
                w_j = 3'(j);
            end
        end
    end

    assign w_advance  = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign o_job_free = (r_mask == '0) || (w_advance && (w_rest == '0));
    assign w_seq      = r_seq_base + 64'(w_j);

    always_comb begin
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_advance) begin
            n_mask      = w_rest;
            n_out_valid = 1'b1;
            n_out.result_kind     = r_kind;
            n_out.seq_high        = w_seq[63:32];
            n_out.seq_low         = w_seq[31:0];
            n_out.reader_entity   = i_hdr.reader_entity;
            n_out.writer_entity   = i_hdr.writer_entity;
            n_out.count_value     = r_count;
            n_out.submessage_kind = i_hdr.submessage_kind;
            n_out.header_flags    = i_hdr.header_flags;
            n_out.body_length     = i_hdr.body_length;
            n_out.bit_count       = i_hdr.bit_count;
            n_out.last_result     = (w_rest == '0);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_load) begin
            n_mask = i_job.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_load) begin
            r_seq_base <= i_job.seq_base;
            r_kind     <= i_job.result_kind;
            r_count    <= i_job.count_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/acknack_submessage_parser_core.sv -----
// Top level of the acknowledgement submessage parser.
// Instantiates ackn_parser and ackn_emitter; depends on ackn_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                  Payload                    Moves
// -------  -------------------------  -------------------------  ----------------------------
// input    i_in_valid / o_in_ready    i_in_data  (t_in_item)     one submessage byte
// output   o_out_valid / i_out_ready  o_out_data (t_out_item)    one sequence number or summary
//
// An accepted input transaction loads its job into the job register; as soon as the output
// allows, the first result then moves from the job register into the result register, which
// drives o_out_valid. A byte that yields at most one result does not hold up the next byte,
// so header, count and sparse bitmap bytes flow at one per cycle while the output is not
// stalled. A bitmap byte with several qualifying set bits holds the single job register
// until it has drained, one bit per result and one bit per cycle while the output is not stalled.
// Reset is synchronous and returns the parser to the kind byte with all state cleared. When
// the output is stalled the result register holds its transaction and input is taken only
// while the job register has room.

module acknack_submessage_parser_core #(
    parameter int unsigned MAX_BITS = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ackn_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ackn_pkg::t_out_item     o_out_data
);

    logic                w_job_free;
    logic                w_accept;
    ackn_pkg::t_job      w_job;
    ackn_pkg::t_hdr_info w_hdr;

    // A byte is taken whenever the job register is empty or is about to empty this cycle.
    assign o_in_ready = w_job_free;
    assign w_accept   = i_in_valid && w_job_free;

    // The parser walks the header, bitmap and count fields and builds one job per byte.
    ackn_parser #(
        .MAX_BITS (MAX_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .o_job    (w_job),
        .o_hdr    (w_hdr)
    );

    // The emitter holds the job and turns each pending bit into one output transaction.
    // Header fields are read live from the parser; they cannot change while a job drains,
    // because the next byte is accepted only at the edge that takes the job's last result.
    ackn_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_job       (w_job),
        .i_hdr       (w_hdr),
        .o_job_free  (w_job_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- sim/ackn_checker.sv -----
// Scoreboard for the acknowledgement submessage parser testbench.
// Watches both transaction channels, predicts results from accepted bytes and compares them.
// Depends on ackn_pkg.
`timescale 1ns / 1ps

module ackn_checker
    import ackn_pkg::*;
#(
    parameter int unsigned MAX_BITS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    // Parser state as the block should hold it.
    int unsigned hdr_pos;
    logic        little;
    logic [63:0] field_acc;
    logic [31:0] base_hi;
    logic [31:0] base_lo;
    logic [31:0] bits_seen;
    logic [31:0] bitmap_left;
    logic [7:0]  kind_seen;
    logic [7:0]  flags_seen;
    logic [15:0] length_seen;
    logic [31:0] reader_seen;
    logic [31:0] writer_seen;

    t_out_item   pending_results[$];
    int          fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
    end

    function automatic logic [31:0] bitmap_bytes(input logic [31:0] nbits);
        logic [63:0] words;
        words = (64'(nbits) + 64'd31) / 64'd32;
        return 32'(words * 64'd4);
    endfunction

    // Entity ids are always taken most significant byte first; the ordered numbers
    // follow the flags.
    function automatic logic [31:0] shift_in(input logic [7:0] b, input logic [1:0] k,
                                             input logic ordered);
        if (k == 2'd0) field_acc = '0;
        if (ordered && little) field_acc = field_acc | (64'(b) << (8 * k));
        else field_acc = ((field_acc << 8) | 64'(b)) & 64'hFFFF_FFFF;
        return field_acc[31:0];
    endfunction

    function automatic t_out_item make_result(input logic kind, input logic [63:0] seq,
                                              input logic [31:0] cnt);
        t_out_item r;
        r.result_kind     = kind;
        r.seq_high        = seq[63:32];
        r.seq_low         = seq[31:0];
        r.reader_entity   = reader_seen;
        r.writer_entity   = writer_seen;
        r.count_value     = cnt;
        r.submessage_kind = kind_seen;
        r.header_flags    = flags_seen;
        r.body_length     = length_seen;
        r.bit_count       = bits_seen;
        r.last_result     = 1'b0;
        return r;
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf("kind %0d seq %h_%h rd %h wr %h cnt %h sk %h fl %h len %h bits %h last %0d",
                         r.result_kind, r.seq_high, r.seq_low, r.reader_entity,
                         r.writer_entity, r.count_value, r.submessage_kind, r.header_flags,
                         r.body_length, r.bit_count, r.last_result);
    endfunction

    task automatic restart_parse();
        hdr_pos     = 0;
        bitmap_left = '0;
        field_acc   = '0;
    endtask

    task automatic parse_byte(input t_in_item it);
        logic [7:0]  b;
        logic        eom;
        logic [31:0] v;
        logic [1:0]  k;
        logic [63:0] first_bit;
        logic [63:0] bit_idx;
        t_out_item   r;
        int          made;
        int          j;
        b    = it.data_byte;
        eom  = it.end_of_message;
        made = 0;
        if (hdr_pos < POS_BODY) begin
            if (eom) begin
                restart_parse();
            end else begin
                if (hdr_pos == POS_KIND) begin
                    kind_seen = b;
                end else if (hdr_pos == POS_FLAGS) begin
                    little     = b[FLAG_LITTLE_BIT];
                    flags_seen = b;
                end else if (hdr_pos < POS_ENTITY_FIRST) begin
                    v = shift_in(b, 2'(hdr_pos - 2), 1'b1);
                    if (hdr_pos == POS_LEN_LAST) length_seen = v[15:0];
                end else begin
                    k = 2'(hdr_pos - POS_ENTITY_FIRST);
                    v = shift_in(b, k, hdr_pos >= POS_ORDERED_FIRST);
                    if (k == K_LAST) begin
                        case (hdr_pos)
                            POS_READER_LAST:  reader_seen = v;
                            POS_WRITER_LAST:  writer_seen = v;
                            POS_BASE_HI_LAST: base_hi = v;
                            POS_BASE_LO_LAST: base_lo = v;
                            default: begin
                                bits_seen   = v;
                                bitmap_left = bitmap_bytes(v);
                            end
                        endcase
                    end
                end
                hdr_pos = hdr_pos + 1;
            end
        end else if (bitmap_left != 0) begin
            if (eom) begin
                restart_parse();
            end else begin
                first_bit = (64'(bitmap_bytes(bits_seen)) - 64'(bitmap_left)) * 64'd8;
                for (j = 0; j < 8; j++) begin
                    bit_idx = first_bit + 64'(j);
                    if (b[7 - j] && bit_idx < 64'(bits_seen) && bit_idx < 64'(MAX_BITS)) begin
                        pending_results.push_back(
                            make_result(RES_SEQ, {base_hi, base_lo} + bit_idx, '0));
                        made++;
                    end
                end
                if (made > 0) begin
                    r = pending_results.pop_back();
                    r.last_result = 1'b1;
                    pending_results.push_back(r);
                end
                bitmap_left = bitmap_left - 1;
            end
        end else begin
            k = 2'(hdr_pos - POS_BODY);
            if (eom && k != K_LAST) begin
                restart_parse();
            end else begin
                v = shift_in(b, k, 1'b1);
                if (k != K_LAST) begin
                    hdr_pos = hdr_pos + 1;
                end else begin
                    r = make_result(RES_SUMMARY, {base_hi, base_lo}, v);
                    r.last_result = 1'b1;
                    pending_results.push_back(r);
                    restart_parse();
                end
            end
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        logic      bad;
        if (pending_results.size() == 0) begin
            fails++;
            if (fails <= 10) $display("[%0t] unexpected result: %s", $realtime, show(got));
        end else begin
            want = pending_results.pop_front();
            bad = (got.result_kind !== want.result_kind)
                | (got.seq_high !== want.seq_high)
                | (got.seq_low !== want.seq_low)
                | (got.reader_entity !== want.reader_entity)
                | (got.writer_entity !== want.writer_entity)
                | (got.count_value !== want.count_value)
                | (got.submessage_kind !== want.submessage_kind)
                | (got.header_flags !== want.header_flags)
                | (got.body_length !== want.body_length)
                | (got.bit_count !== want.bit_count)
                | (got.last_result !== want.last_result);
            if (bad) begin
                fails++;
                if (fails <= 10) begin
                    $display("[%0t] result mismatch", $realtime);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_parse();
            little      = 1'b0;
            base_hi     = '0;
            base_lo     = '0;
            bits_seen   = '0;
            kind_seen   = '0;
            flags_seen  = '0;
            length_seen = '0;
            reader_seen = '0;
            writer_seen = '0;
            pending_results.delete();
        end else begin
            // A result never leaves in the cycle its byte is taken, so the output side
            // is checked first.
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) parse_byte(i_in_data);
        end
        o_fail_count <= fails;
        o_pending    <= pending_results.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the acknowledgement submessage parser testbench: clock, reset, stimulus and verdict.
// Instantiates acknack_submessage_parser_core and ackn_checker; depends on ackn_pkg.
`timescale 1ns / 1ps

module tb_top;
    import ackn_pkg::*;

    localparam int unsigned MAX_BITS = 256;

    // The receiver holds off this long once, so the parser fills and stalls its input.
    localparam int HOLD_CYCLES  = 400;
    // Cycles without any accepted transaction before the run is declared hung. The slowest
    // correct stretch is the long hold-off plus one of the longest random gaps.
    localparam int IDLE_LIMIT   = 5000;
    // Quiet cycles after the last expected result, to catch stray extra results.
    localparam int DRAIN_CYCLES = 20;
    // Approximate number of bytes for the whole run, the directed part included.
    localparam int TOTAL_BYTES  = 380;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data  = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int        fail_count;
    int        pending;

    // The stimulus asks for the long receiver hold-off by bumping stall_requests; the
    // receiver process acknowledges each request through stalls_done.
    int        stall_requests = 0;
    int        stalls_done    = 0;

    // Set per segment: when high the sender offers bytes back to back with no gaps.
    bit        sender_calm = 1'b0;
    int        sent_bytes  = 0;

    // One submessage to send. Bitmap bytes are drawn from fill_pct, the chance in percent
    // that each bitmap bit is set.
    typedef struct {
        logic [7:0]  kind;
        logic [7:0]  flags;
        logic [15:0] length;
        logic [31:0] reader;
        logic [31:0] writer;
        logic [31:0] base_hi;
        logic [31:0] base_lo;
        logic [31:0] bits;
        logic [31:0] count;
        int          fill_pct;
        int          cut_at;    // index of the byte that carries an early end, or -1
        logic        end_mark;  // end mark on the last count byte
    } t_plan;

    t_in_item stream_q[$];
    t_in_item msg_q[$];

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    acknack_submessage_parser_core #(
        .MAX_BITS(MAX_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    ackn_checker #(
        .MAX_BITS(MAX_BITS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        t_in_item it;
        it.data_byte      = b;
        it.end_of_message = 1'b0;
        msg_q.push_back(it);
    endfunction

    // Multibyte numbers go out in the order that the flags select.
    function automatic void put_number(input logic [31:0] value, input int nbytes,
                                       input logic little);
        int i;
        for (i = 0; i < nbytes; i++)
            put_byte(little ? value[8*i +: 8] : value[8*(nbytes-1-i) +: 8]);
    endfunction

    function automatic logic [63:0] map_len_of(input logic [31:0] bits);
        return ((64'(bits) + 64'd31) / 64'd32) * 64'd4;
    endfunction

    function automatic t_plan random_plan();
        t_plan p;
        int    r;
        p.kind    = 8'($urandom);
        p.flags   = 8'($urandom);
        p.length  = 16'($urandom);
        p.reader  = $urandom;
        p.writer  = $urandom;
        p.count   = $urandom;
        // Bases near the top of each half make the carry and the 64-bit wrap likely.
        if ($urandom_range(0, 7) == 0)
            p.base_hi = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        else
            p.base_hi = $urandom;
        if ($urandom_range(0, 3) == 0) p.base_lo = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else p.base_lo = $urandom;
        case ($urandom_range(0, 3))
            0:       p.fill_pct = $urandom_range(0, 15);
            1:       p.fill_pct = 50;
            2:       p.fill_pct = $urandom_range(80, 100);
            default: p.fill_pct = $urandom_range(0, 100);
        endcase
        p.cut_at   = -1;
        p.end_mark = ($urandom_range(0, 9) != 0);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            p.bits = '0;
        end else if (r < 72) begin
            p.bits = $urandom_range(1, 64);
        end else if (r < 90) begin
            p.bits = $urandom_range(65, 320);
        end else begin
            // A bitmap this long can never be sent, so the message is always cut short
            // a few bytes into it.
            p.bits   = $urandom | 32'h0000_1000;
            p.cut_at = 24 + $urandom_range(0, 8);
        end
        if (p.cut_at < 0 && $urandom_range(0, 99) < 12)
            p.cut_at = $urandom_range(0, 27 + int'(map_len_of(p.bits)));
        return p;
    endfunction

    // Appends one submessage to the stream. A cut message ends with the end mark on the
    // cut byte; the parser ends the message there and waits for a new kind byte.
    task automatic build_msg(input t_plan p);
        logic        little;
        logic [63:0] map_len;
        logic [63:0] i;
        int          k;
        logic [7:0]  b;
        t_in_item    last;
        little  = p.flags[FLAG_LITTLE_BIT];
        map_len = map_len_of(p.bits);
        msg_q.delete();
        put_byte(p.kind);
        put_byte(p.flags);
        put_number(32'(p.length), 2, little);
        put_number(p.reader, 4, 1'b0);
        put_number(p.writer, 4, 1'b0);
        put_number(p.base_hi, 4, little);
        put_number(p.base_lo, 4, little);
        put_number(p.bits, 4, little);
        for (i = 0; i < map_len && !(p.cut_at >= 0 && msg_q.size() > p.cut_at); i++) begin
            b = '0;
            for (k = 0; k < 8; k++)
                if ($urandom_range(0, 99) < p.fill_pct) b[7-k] = 1'b1;
            put_byte(b);
        end
        put_number(p.count, 4, little);
        last = msg_q.pop_back();
        last.end_of_message = p.end_mark;
        if (p.cut_at >= 0 && p.cut_at <= msg_q.size()) begin
            msg_q.push_back(last);
            while (msg_q.size() > p.cut_at + 1) void'(msg_q.pop_back());
            last = msg_q.pop_back();
            last.end_of_message = 1'b1;
        end
        msg_q.push_back(last);
        while (msg_q.size() > 0) stream_q.push_back(msg_q.pop_front());
    endtask

    // A few garbage header bytes; the last carries the end mark so the parser is back at
    // the kind byte afterwards.
    task automatic add_noise();
        t_in_item it;
        int       n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            it.data_byte      = 8'($urandom);
            it.end_of_message = ($urandom_range(0, 3) == 0);
            stream_q.push_back(it);
        end
        it = stream_q.pop_back();
        it.end_of_message = 1'b1;
        stream_q.push_back(it);
    endtask

    // Offers one byte and returns at the edge where it is accepted. Valid is never lowered
    // while a byte is waiting.
    task automatic send_byte(input t_in_item it);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // Sends the queued stream, back to back only if sender_calm is drawn high, then drops
    // valid so that the next segment starts clean.
    task automatic flush();
        sender_calm = ($urandom_range(0, 3) == 0);
        while (stream_q.size() > 0) begin
            send_byte(stream_q.pop_front());
            sent_bytes++;
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // The checker's count is registered, so the task lets it update before trusting it.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: random stalls with calm stretches, and the long hold-off on request.
    initial begin : result_sink
        int hold_left;
        int mode_left;
        bit calm;
        hold_left = 0;
        mode_left = 0;
        calm      = 1'b0;
        forever begin
            @(posedge clk);
            if (stalls_done != stall_requests) begin
                stalls_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    calm      = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(20, 120);
                end else begin
                    mode_left--;
                end
                hold_left = calm ? 0 : pick_gap();
                out_ready <= (hold_left == 0);
            end
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_plan p;
        int    seg;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // All-zero submessage with an empty bitmap: the count follows the bit count.
        p = random_plan();
        p.kind = '0; p.flags = '0; p.length = '0; p.reader = '0; p.writer = '0;
        p.base_hi = '0; p.base_lo = '0; p.bits = '0; p.count = '0;
        p.cut_at = -1; p.end_mark = 1'b1;
        build_msg(p);

        // All-ones header in little-endian order; the low half of the base carries into
        // the high half, which turns negative.
        p.kind = 8'hFF; p.flags = 8'hFF; p.length = 16'hFFFF;
        p.reader = 32'hFFFF_FFFF; p.writer = 32'hFFFF_FFFF; p.count = 32'hFFFF_FFFF;
        p.base_hi = 32'h7FFF_FFFF; p.base_lo = 32'hFFFF_FFF8; p.bits = 32; p.fill_pct = 100;
        build_msg(p);

        // Big-endian with all flag bits but the little-endian one set; the base wraps past
        // 2^64, and bits above MAX_BITS and above the bit count are consumed but give nothing.
        p.flags = 8'hFE; p.base_hi = 32'hFFFF_FFFF; p.base_lo = 32'hFFFF_FFFC;
        p.bits = 300; p.fill_pct = 40; p.length = 16'h0102;
        build_msg(p);
        flush();
        wait_drained();

        // A bit count that ends mid-byte, and a message without an end mark followed
        // directly by the next one.
        p = random_plan();
        p.bits = 5; p.fill_pct = 100; p.cut_at = -1; p.end_mark = 1'b0; p.flags = 8'h00;
        build_msg(p);
        p = random_plan();
        p.bits = 13; p.fill_pct = 100; p.cut_at = -1; p.end_mark = 1'b1; p.flags = 8'h01;
        build_msg(p);

        // Early ends: on the kind byte, inside the header, inside the bitmap and inside
        // the count.
        p = random_plan();
        p.bits = 64; p.fill_pct = 100; p.end_mark = 1'b1;
        p.cut_at = 0;
        build_msg(p);
        p.cut_at = 10;
        build_msg(p);
        p.cut_at = 26;
        build_msg(p);
        p.bits = 8; p.cut_at = 29;
        build_msg(p);
        p.cut_at = -1;
        build_msg(p);
        flush();
        wait_drained();

        // Pressure: the receiver holds off while dense bitmaps keep coming, so the parser
        // fills and stops taking bytes. Then the sender waits for every result.
        stall_requests++;
        p = random_plan();
        p.bits = 64; p.fill_pct = 100; p.cut_at = -1; p.end_mark = 1'b1;
        build_msg(p);
        build_msg(p);
        flush();
        wait_drained();

        // Random part: mostly well-formed submessages with random content, some cut short,
        // some noise; the sender pauses for a full drain now and then. It runs until the
        // whole run has sent about TOTAL_BYTES bytes.
        while (sent_bytes < TOTAL_BYTES) begin
            seg = $urandom_range(1, 2);
            repeat (seg) begin
                if ($urandom_range(0, 99) < 8) add_noise();
                else build_msg(random_plan());
            end
            flush();
            if ($urandom_range(0, 3) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
